@@ design/bdqs_pkg.sv @@
// Shared types and constants for the bounded deque with search.
`timescale 1ns / 1ps

package bdqs_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int DATA_W       = 32;
	localparam int MODE_W       = 3;
	localparam int COUNT_W      = 5;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT_IN,
		CELL_SHIFT_OUT,
		CELL_APPEND,
		CELL_TRIM,
		CELL_CLEAR,
		CELL_SEARCH
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ design/bdqs_if.sv @@
// Valid/ready channel interfaces for request and result transfers.
`timescale 1ns / 1ps

interface bdqs_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [bdqs_pkg::MODE_W-1:0]           mode;
	logic signed [bdqs_pkg::DATA_W-1:0]    value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface bdqs_out_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  found;
	logic signed [bdqs_pkg::DATA_W-1:0]    front_value;
	logic signed [bdqs_pkg::DATA_W-1:0]    back_value;
	logic [bdqs_pkg::COUNT_W-1:0]          entry_count;
	logic                                  is_empty;
	logic                                  dropped;

	modport source (output valid, output found, output front_value, output back_value,
		output entry_count, output is_empty, output dropped, input ready);
	modport sink (input valid, input found, input front_value, input back_value,
		input entry_count, input is_empty, input dropped, output ready);
endinterface

@@ design/bdqs_cell.sv @@
// One deque cell: holds an entry, shifts with its neighbors and compares for search.
`timescale 1ns / 1ps

module bdqs_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdqs_pkg::cell_cmd_t               cmd,
	input  logic signed [bdqs_pkg::DATA_W-1:0] left_data,
	input  logic                              left_valid,
	input  logic signed [bdqs_pkg::DATA_W-1:0] right_data,
	input  logic                              right_valid,
	output logic signed [bdqs_pkg::DATA_W-1:0] data,
	output logic                              valid,
	output logic                              hit
);

	logic signed [bdqs_pkg::DATA_W-1:0] data_q;
	logic                               valid_q;
	logic                               hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.op != bdqs_pkg::CELL_HOLD) begin
				hit_q <= (cmd.op == bdqs_pkg::CELL_SEARCH) && valid_q && (data_q == cmd.value);
			end
			case (cmd.op)
				bdqs_pkg::CELL_SHIFT_IN:  valid_q <= left_valid;
				bdqs_pkg::CELL_SHIFT_OUT: valid_q <= right_valid;
				bdqs_pkg::CELL_APPEND: begin
					if (!valid_q && left_valid) begin
						valid_q <= 1'b1;
					end
				end
				bdqs_pkg::CELL_TRIM: begin
					if (valid_q && !right_valid) begin
						valid_q <= 1'b0;
					end
				end
				bdqs_pkg::CELL_CLEAR: valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bdqs_pkg::CELL_SHIFT_IN:  data_q <= left_data;
			bdqs_pkg::CELL_SHIFT_OUT: data_q <= right_data;
			bdqs_pkg::CELL_APPEND: begin
				if (!valid_q && left_valid) begin
					data_q <= cmd.value;
				end
			end
			default: ;
		endcase
	end

	assign data  = data_q;
	assign valid = valid_q;
	assign hit   = hit_q;

endmodule

@@ design/bounded_deque_with_search_top.sv @@
// Top level of the bounded deque with search: command decode, cell row and result register.
//
//   channel  direction  payload                                               transfer
//   in_ch    sink       mode, value                                           valid && ready
//   out_ch   source     found, front_value, back_value, entry_count,          valid && ready
//                       is_empty, dropped
//
// Each request is handled in order: first every cell shifts or compares, then the cell
// row is reduced into the result register. The next request is taken once the
// reduce cycle is done, even while the previous result still waits on out_ch.
// A stalled result holds the reduce cycle, and with it in_ch, until the slot frees.
// Reset empties the row at once; entry contents are not cleared.
`timescale 1ns / 1ps

module bounded_deque_with_search_top #(
	parameter int CAPACITY = bdqs_pkg::DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	bdqs_in_if.sink           in_ch,
	bdqs_out_if.source        out_ch
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [bdqs_pkg::DATA_W-1:0] cell_data  [CAPACITY];
	logic [CAPACITY-1:0]                cell_valid;
	logic [CAPACITY-1:0]                cell_hit;
	bdqs_pkg::cell_cmd_t                cmd;

	logic             busy_q;
	logic             dropped_s1;
	logic             search_s1;
	logic [CNT_W-1:0] count_q;

	logic                               out_valid_q;
	logic                               found_q;
	logic signed [bdqs_pkg::DATA_W-1:0] front_q;
	logic signed [bdqs_pkg::DATA_W-1:0] back_q;
	logic [bdqs_pkg::COUNT_W-1:0]       entry_count_q;
	logic                               empty_q;
	logic                               dropped_q;

	logic                               accept;
	logic                               full;
	logic                               empty;
	logic                               push_ok;
	logic                               pop_ok;
	logic                               drop;
	logic                               result_load;
	logic signed [bdqs_pkg::DATA_W-1:0] back_sel;

	assign in_ch.ready = !busy_q;
	assign accept      = in_ch.valid && in_ch.ready;
	assign full        = cell_valid[CAPACITY-1];
	assign empty       = !cell_valid[0];

	always_comb begin
		cmd.value = in_ch.value;
		cmd.op    = bdqs_pkg::CELL_HOLD;
		push_ok   = 1'b0;
		pop_ok    = 1'b0;
		drop      = 1'b0;
		if (accept) begin
			unique case (in_ch.mode)
				bdqs_pkg::MODE_PUSH_FRONT: begin
					push_ok = !full;
					drop    = full;
					if (!full) begin
						cmd.op = bdqs_pkg::CELL_SHIFT_IN;
					end
				end
				bdqs_pkg::MODE_PUSH_BACK: begin
					push_ok = !full;
					drop    = full;
					if (!full) begin
						cmd.op = bdqs_pkg::CELL_APPEND;
					end
				end
				bdqs_pkg::MODE_POP_FRONT: begin
					pop_ok = !empty;
					cmd.op = bdqs_pkg::CELL_SHIFT_OUT;
				end
				bdqs_pkg::MODE_POP_BACK: begin
					pop_ok = !empty;
					cmd.op = bdqs_pkg::CELL_TRIM;
				end
				bdqs_pkg::MODE_SEARCH: cmd.op = bdqs_pkg::CELL_SEARCH;
				bdqs_pkg::MODE_CLEAR:  cmd.op = bdqs_pkg::CELL_CLEAR;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [bdqs_pkg::DATA_W-1:0] l_data;
		logic                               l_valid;
		logic signed [bdqs_pkg::DATA_W-1:0] r_data;
		logic                               r_valid;

		if (i == 0) begin : g_first
			assign l_data  = cmd.value;
			assign l_valid = 1'b1;
		end else begin : g_mid_l
			assign l_data  = cell_data[i-1];
			assign l_valid = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_mid_r
			assign r_data  = cell_data[i+1];
			assign r_valid = cell_valid[i+1];
		end

		bdqs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.hit         (cell_hit[i])
		);
	end

	always_comb begin
		back_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_valid[i] && (i == CAPACITY - 1 || !cell_valid[(i + 1) % CAPACITY])) begin
				back_sel = back_sel | cell_data[i];
			end
		end
	end

	assign result_load = busy_q && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			dropped_s1  <= 1'b0;
			search_s1   <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q     <= 1'b1;
				dropped_s1 <= drop;
				search_s1  <= (in_ch.mode == bdqs_pkg::MODE_SEARCH);
				if (in_ch.mode == bdqs_pkg::MODE_CLEAR) begin
					count_q <= '0;
				end else if (push_ok) begin
					count_q <= count_q + CNT_W'(1);
				end else if (pop_ok) begin
					count_q <= count_q - CNT_W'(1);
				end
			end else if (result_load) begin
				busy_q <= 1'b0;
			end
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			found_q       <= search_s1 && (|cell_hit);
			front_q       <= empty ? bdqs_pkg::EMPTY_VALUE : cell_data[0];
			back_q        <= empty ? bdqs_pkg::EMPTY_VALUE : back_sel;
			entry_count_q <= bdqs_pkg::COUNT_W'(count_q);
			empty_q       <= empty;
			dropped_q     <= dropped_s1;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.found       = found_q;
	assign out_ch.front_value = front_q;
	assign out_ch.back_value  = back_q;
	assign out_ch.entry_count = entry_count_q;
	assign out_ch.is_empty    = empty_q;
	assign out_ch.dropped     = dropped_q;

	a_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("occupied cells are not contiguous from the front");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("entry count disagrees with occupied cells");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("request transfer did not start the reduce cycle");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> (empty_q == (count_q == '0)))
		else $error("empty flag disagrees with entry count");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the bounded deque with search: directed script, then random traffic.
`timescale 1ns / 1ps

module tb_top;

	localparam int CAP          = bdqs_pkg::DEF_CAPACITY;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 110;
	localparam int DRAIN_LIMIT  = 20000;

	localparam logic [bdqs_pkg::MODE_W-1:0] MODE_RESERVED_LO = 3'd6;
	localparam logic [bdqs_pkg::MODE_W-1:0] MODE_RESERVED_HI = 3'd7;

	localparam logic signed [bdqs_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [bdqs_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

	typedef struct packed {
		logic                               found;
		logic signed [bdqs_pkg::DATA_W-1:0] front_value;
		logic signed [bdqs_pkg::DATA_W-1:0] back_value;
		logic [bdqs_pkg::COUNT_W-1:0]       entry_count;
		logic                               is_empty;
		logic                               dropped;
	} deque_result_t;

	typedef struct packed {
		logic [bdqs_pkg::MODE_W-1:0]        mode;
		logic signed [bdqs_pkg::DATA_W-1:0] value;
		logic                               typed;
		deque_result_t                      res;
	} script_row_t;

	localparam deque_result_t EMPTY_RES = '{1'b0, bdqs_pkg::EMPTY_VALUE, bdqs_pkg::EMPTY_VALUE,
		5'd0, 1'b1, 1'b0};
	localparam deque_result_t NO_RES    = '0;

	localparam int SCRIPT_LEN = 18;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{bdqs_pkg::MODE_POP_FRONT,  32'sd0,        1'b1, EMPTY_RES},
		'{bdqs_pkg::MODE_POP_BACK,   32'sd0,        1'b1, EMPTY_RES},
		'{bdqs_pkg::MODE_SEARCH,     32'sd0,        1'b1, EMPTY_RES},
		'{MODE_RESERVED_LO,          VAL_MAX,       1'b1, EMPTY_RES},
		'{bdqs_pkg::MODE_PUSH_FRONT, VAL_MAX,       1'b1,
			'{1'b0, VAL_MAX, VAL_MAX, 5'd1, 1'b0, 1'b0}},
		'{bdqs_pkg::MODE_PUSH_BACK,  VAL_MIN,       1'b1,
			'{1'b0, VAL_MAX, VAL_MIN, 5'd2, 1'b0, 1'b0}},
		'{bdqs_pkg::MODE_SEARCH,     VAL_MIN,       1'b1,
			'{1'b1, VAL_MAX, VAL_MIN, 5'd2, 1'b0, 1'b0}},
		'{bdqs_pkg::MODE_SEARCH,     32'sd0,        1'b1,
			'{1'b0, VAL_MAX, VAL_MIN, 5'd2, 1'b0, 1'b0}},
		'{bdqs_pkg::MODE_POP_FRONT,  32'sd0,        1'b1,
			'{1'b0, VAL_MIN, VAL_MIN, 5'd1, 1'b0, 1'b0}},
		'{bdqs_pkg::MODE_POP_BACK,   32'sd0,        1'b1, EMPTY_RES},
		'{bdqs_pkg::MODE_PUSH_BACK,  -32'sd1,       1'b1,
			'{1'b0, -32'sd1, -32'sd1, 5'd1, 1'b0, 1'b0}},
		'{bdqs_pkg::MODE_PUSH_FRONT, 32'sh00000001, 1'b0, NO_RES},
		'{bdqs_pkg::MODE_PUSH_BACK,  32'shAAAAAAAA, 1'b0, NO_RES},
		'{bdqs_pkg::MODE_SEARCH,     32'shAAAAAAAA, 1'b0, NO_RES},
		'{bdqs_pkg::MODE_SEARCH,     32'sh55555555, 1'b0, NO_RES},
		'{MODE_RESERVED_HI,          32'sh55555555, 1'b0, NO_RES},
		'{bdqs_pkg::MODE_POP_FRONT,  32'sd0,        1'b0, NO_RES},
		'{bdqs_pkg::MODE_CLEAR,      VAL_MIN,       1'b1, EMPTY_RES}
	};

	logic clk;
	logic arst_n;

	bdqs_in_if  in_ch ();
	bdqs_out_if out_ch ();

	bounded_deque_with_search_top #(.CAPACITY(CAP)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	logic signed [bdqs_pkg::DATA_W-1:0] mirror [CAP];
	int                                 head_pos;
	int                                 fill;
	deque_result_t                      expected_q [$];
	logic signed [bdqs_pkg::DATA_W-1:0] value_pool [$];

	int fails;
	int transfers;
	int search_hits;
	int refused_pushes;
	int empty_pops;
	int src_idle_pct;
	int snk_stall_pct;
	int hold_req;
	int hold_seen;
	int hold_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic deque_result_t apply_op(logic [bdqs_pkg::MODE_W-1:0] m,
			logic signed [bdqs_pkg::DATA_W-1:0] v);
		deque_result_t r;
		r = '0;
		case (m)
			bdqs_pkg::MODE_PUSH_FRONT, bdqs_pkg::MODE_PUSH_BACK: begin
				if (fill >= CAP) begin
					r.dropped = 1'b1;
					refused_pushes++;
				end else if (m == bdqs_pkg::MODE_PUSH_FRONT) begin
					head_pos = (head_pos + CAP - 1) % CAP;
					mirror[head_pos] = v;
					fill++;
				end else begin
					mirror[(head_pos + fill) % CAP] = v;
					fill++;
				end
			end
			bdqs_pkg::MODE_POP_FRONT, bdqs_pkg::MODE_POP_BACK: begin
				if (fill == 0) begin
					empty_pops++;
				end else begin
					if (m == bdqs_pkg::MODE_POP_FRONT)
						head_pos = (head_pos + 1) % CAP;
					fill--;
				end
			end
			bdqs_pkg::MODE_SEARCH: begin
				for (int i = 0; i < fill; i++)
					if (mirror[(head_pos + i) % CAP] == v)
						r.found = 1'b1;
				if (r.found)
					search_hits++;
			end
			bdqs_pkg::MODE_CLEAR: begin
				fill = 0;
				head_pos = 0;
			end
			default: ;
		endcase
		if (fill == 0) begin
			r.front_value = bdqs_pkg::EMPTY_VALUE;
			r.back_value = bdqs_pkg::EMPTY_VALUE;
		end else begin
			r.front_value = mirror[head_pos];
			r.back_value = mirror[(head_pos + fill - 1) % CAP];
		end
		r.entry_count = fill[bdqs_pkg::COUNT_W-1:0];
		r.is_empty = (fill == 0);
		return r;
	endfunction

	task automatic send_op(input logic [bdqs_pkg::MODE_W-1:0] m,
			input logic signed [bdqs_pkg::DATA_W-1:0] v,
			input logic typed, input deque_result_t typed_res);
		deque_result_t r;
		while ($urandom_range(99, 0) < src_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.mode = m;
		in_ch.value = v;
		do @(posedge clk); while (!in_ch.ready);
		r = apply_op(m, v);
		expected_q.push_back(typed ? typed_res : r);
		if (m == bdqs_pkg::MODE_PUSH_FRONT || m == bdqs_pkg::MODE_PUSH_BACK) begin
			value_pool.push_back(v);
			if (value_pool.size() > 32)
				void'(value_pool.pop_front());
		end
		@(negedge clk);
	endtask

	function automatic logic signed [bdqs_pkg::DATA_W-1:0] pick_value(int pool_pct);
		int r;
		r = $urandom_range(99, 0);
		if (r < pool_pct && value_pool.size() > 0)
			return value_pool[$urandom_range(value_pool.size() - 1, 0)];
		if (r < pool_pct + 15) begin
			case ($urandom_range(3, 0))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom();
	endfunction

	task automatic send_random(int bias);
		int push_pct, pop_pct, search_pct, r;
		logic [bdqs_pkg::MODE_W-1:0] m;
		logic signed [bdqs_pkg::DATA_W-1:0] v;
		case (bias)
			0: begin push_pct = 65; pop_pct = 10; search_pct = 20; end
			1: begin push_pct = 15; pop_pct = 60; search_pct = 20; end
			default: begin push_pct = 35; pop_pct = 30; search_pct = 30; end
		endcase
		r = $urandom_range(99, 0);
		if (r < push_pct) begin
			m = $urandom_range(1, 0) ? bdqs_pkg::MODE_PUSH_BACK : bdqs_pkg::MODE_PUSH_FRONT;
			v = pick_value(25);
		end else if (r < push_pct + pop_pct) begin
			m = $urandom_range(1, 0) ? bdqs_pkg::MODE_POP_BACK : bdqs_pkg::MODE_POP_FRONT;
			v = $urandom();
		end else if (r < push_pct + pop_pct + search_pct) begin
			m = bdqs_pkg::MODE_SEARCH;
			v = pick_value(60);
		end else if (r < 97) begin
			m = bdqs_pkg::MODE_CLEAR;
			v = $urandom();
		end else begin
			m = $urandom_range(1, 0) ? MODE_RESERVED_HI : MODE_RESERVED_LO;
			v = $urandom();
		end
		send_op(m, v, 1'b0, NO_RES);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int items);
		int bias;
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		bias = 2;
		for (int n = 0; n < items; n++) begin
			if (n % 24 == 0)
				bias = $urandom_range(2, 0);
			send_random(bias);
		end
	endtask

	function automatic void compare_field(string name, logic [bdqs_pkg::DATA_W-1:0] exp_v,
			logic [bdqs_pkg::DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		deque_result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			transfers++;
			if (expected_q.size() == 0) begin
				$error("result transfer with no pending request");
				fails++;
			end else begin
				e = expected_q.pop_front();
				compare_field("found", e.found, out_ch.found);
				compare_field("front_value", e.front_value, out_ch.front_value);
				compare_field("back_value", e.back_value, out_ch.back_value);
				compare_field("entry_count", e.entry_count, out_ch.entry_count);
				compare_field("is_empty", e.is_empty, out_ch.is_empty);
				compare_field("dropped", e.dropped, out_ch.dropped);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
		end
		if (hold_left > 0) begin
			out_ch.ready = 1'b0;
			hold_left--;
		end else begin
			out_ch.ready = ($urandom_range(99, 0) >= snk_stall_pct);
		end
	end

	initial begin
		#(400000 * 12);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int waited;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = bdqs_pkg::MODE_SEARCH;
		in_ch.value = '0;
		fails = 0;
		transfers = 0;
		search_hits = 0;
		refused_pushes = 0;
		empty_pops = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		head_pos = 0;
		fill = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (SCRIPT[k])
			send_op(SCRIPT[k].mode, SCRIPT[k].value, SCRIPT[k].typed, SCRIPT[k].res);

		run_phase(0, 0, PHASE_ITEMS);
		run_phase(70, 0, PHASE_ITEMS);
		run_phase(0, 70, PHASE_ITEMS);
		run_phase(13, 13, PHASE_ITEMS);
		hold_req++;
		run_phase(0, 0, PHASE_ITEMS);

		in_ch.valid = 1'b0;
		snk_stall_pct = 0;
		waited = 0;
		while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			fails++;
		end

		$display("Checked %0d result transfers over five stall patterns and a long receiver hold.",
			transfers);
		$display("Saw %0d search hits, %0d refused pushes, %0d pops on an empty queue.",
			search_hits, refused_pushes, empty_pops);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/bdqs_pkg.sv
design/bdqs_if.sv
design/bdqs_cell.sv
design/bounded_deque_with_search_top.sv
tb/tb_top.sv
